### rtl/grx_pkg.sv
// ----------------------------------------------------------------------------
// grx_pkg
// Shared types, constants and the RGB444 palette for the glyph row expander.
// ----------------------------------------------------------------------------
package grx_pkg;

  localparam int PALETTE_SIZE = 11;
  localparam int MAX_PAIRS    = 4;
  localparam int QUEUE_DEPTH  = 2;

  localparam int ROW_W   = 8;
  localparam int IDX_W   = 4;
  localparam int GW_W    = 4;
  localparam int PAIRS_W = 3;
  localparam int COLOR_W = 12;
  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FG_INDEX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_INDEX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH = 2'd2;

  localparam logic [IDX_W-1:0] FG_RESET = 4'd1;
  localparam logic [IDX_W-1:0] BG_RESET = 4'd0;
  localparam logic [GW_W-1:0]  GW_RESET = 4'd8;

  // byte position within one pixel pair
  localparam logic [1:0] SEL_RG = 2'd0;
  localparam logic [1:0] SEL_BR = 2'd1;
  localparam logic [1:0] SEL_GB = 2'd2;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [PAIRS_W-1:0] pairs;
  } row_entry_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel_byte;
    logic              last_byte;
  } out_entry_t;

  typedef struct packed {
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
  } colors_t;

  typedef struct packed {
    logic busy;
    logic issue;
  } back_status_t;

  function automatic logic [COLOR_W-1:0] color_of(input logic [IDX_W-1:0] idx);
    logic [COLOR_W-1:0] c;
    case (idx)
      4'd0:    c = 12'hFFF;
      4'd1:    c = 12'h000;
      4'd2:    c = 12'hF00;
      4'd3:    c = 12'h0F0;
      4'd4:    c = 12'h00F;
      4'd5:    c = 12'h0FF;
      4'd6:    c = 12'hF0F;
      4'd7:    c = 12'hFF0;
      4'd8:    c = 12'hB22;
      4'd9:    c = 12'hFA0;
      4'd10:   c = 12'hF6A;
      default: c = 12'h000;
    endcase
    return c;
  endfunction

endpackage

### rtl/glyph_row_to_rgb444_expander.sv
// ----------------------------------------------------------------------------
// glyph_row_to_rgb444_expander
// Expands two-color glyph rows into packed RGB444 display bytes.
// ----------------------------------------------------------------------------
// path: a row passes the row queue, the byte sequencer and the output queue
// throughput: one output byte per cycle while the output queue is not full,
//   three bytes per pixel pair, twelve per row at glyph width 7 or more
// rows with glyph width 0 are taken and produce nothing
// reset: synchronous active-low rst_n empties both queues and restores
//   fg_index 1, bg_index 0, glyph_width 8
module glyph_row_to_rgb444_expander #(
  parameter int QUEUE_DEPTH = grx_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [grx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [grx_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [grx_pkg::ROW_W-1:0]      in_glyph_row,
  input  logic                           out_pop,
  output logic                           out_empty,
  output logic [grx_pkg::BYTE_W-1:0]     out_pixel_byte,
  output logic                           out_last_byte
);

  logic                  q_push, q_pop, q_full, q_empty;
  grx_pkg::row_entry_t   q_wdata, q_rdata;
  grx_pkg::colors_t      colors;
  logic                  o_push, o_full;
  grx_pkg::out_entry_t   o_wdata, o_rdata;
  grx_pkg::back_status_t status;

  grx_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_push      (in_push),
    .in_glyph_row (in_glyph_row),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata),
    .colors       (colors)
  );

  grx_fifo #(
    .WIDTH ($bits(grx_pkg::row_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_row_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  grx_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .colors  (colors),
    .q_empty (q_empty),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .o_full  (o_full),
    .o_push  (o_push),
    .o_wdata (o_wdata),
    .status  (status)
  );

  grx_fifo #(
    .WIDTH ($bits(grx_pkg::out_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .wdata (o_wdata),
    .full  (o_full),
    .pop   (out_pop),
    .rdata (o_rdata),
    .empty (out_empty)
  );

  assign in_full        = q_full;
  assign out_pixel_byte = o_rdata.pixel_byte;
  assign out_last_byte  = o_rdata.last_byte;

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    status.issue |-> !o_full)
    else $error("byte issued into a full output queue");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("waiting result lost without transfer");

  a_no_invented_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (!status.busy && q_empty && out_empty) |=> out_empty)
    else $error("result appeared with no row in progress");

  a_idle_no_issue: assert property (@(posedge clk) disable iff (!rst_n)
    !status.busy |-> !o_push)
    else $error("byte issued while sequencer idle");
`endif

endmodule

### rtl/grx_fifo.sv
// ----------------------------------------------------------------------------
// grx_fifo
// Small synchronous queue with full and empty flags.
// ----------------------------------------------------------------------------
module grx_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = grx_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = data_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### rtl/grx_front.sv
// ----------------------------------------------------------------------------
// grx_front
// Configuration registers, pair count and intake of glyph rows.
// ----------------------------------------------------------------------------
module grx_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [grx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [grx_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_push,
  input  logic [grx_pkg::ROW_W-1:0]           in_glyph_row,
  input  logic                                q_full,
  output logic                                q_push,
  output grx_pkg::row_entry_t                 q_wdata,
  output grx_pkg::colors_t                    colors
);

  logic [grx_pkg::IDX_W-1:0]   fg_r, fg_nxt;
  logic [grx_pkg::IDX_W-1:0]   bg_r, bg_nxt;
  logic [grx_pkg::GW_W-1:0]    gw_r, gw_nxt;
  logic                        idx_ok;
  logic [grx_pkg::GW_W-1:0]    half;
  logic [grx_pkg::PAIRS_W-1:0] pairs;

  assign idx_ok = ({1'b0, cfg_wdata} < 5'(grx_pkg::PALETTE_SIZE));

  always_comb begin
    fg_nxt = fg_r;
    bg_nxt = bg_r;
    gw_nxt = gw_r;
    if (cfg_we) begin
      case (cfg_index)
        grx_pkg::REG_FG_INDEX: begin
          if (idx_ok) begin
            fg_nxt = cfg_wdata;
          end
        end
        grx_pkg::REG_BG_INDEX: begin
          if (idx_ok) begin
            bg_nxt = cfg_wdata;
          end
        end
        grx_pkg::REG_GLYPH_WIDTH: begin
          gw_nxt = cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= grx_pkg::FG_RESET;
      bg_r <= grx_pkg::BG_RESET;
      gw_r <= grx_pkg::GW_RESET;
    end else begin
      fg_r <= fg_nxt;
      bg_r <= bg_nxt;
      gw_r <= gw_nxt;
    end
  end

  // pairs = ceil(width / 2), saturated
  assign half  = 4'(({1'b0, gw_r} + 5'd1) >> 1);
  assign pairs = (half > 4'(grx_pkg::MAX_PAIRS)) ? 3'(grx_pkg::MAX_PAIRS) : half[2:0];

  // rows with no pairs are taken and dropped
  assign q_push        = in_push && !q_full && (pairs != '0);
  assign q_wdata.row   = in_glyph_row;
  assign q_wdata.pairs = pairs;

  assign colors.fg_color = grx_pkg::color_of(fg_r);
  assign colors.bg_color = grx_pkg::color_of(bg_r);

endmodule

### rtl/grx_back.sv
// ----------------------------------------------------------------------------
// grx_back
// Byte sequencer: expands one queued row into packed RGB444 bytes.
// ----------------------------------------------------------------------------
module grx_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  grx_pkg::colors_t       colors,
  input  logic                   q_empty,
  input  grx_pkg::row_entry_t    q_rdata,
  output logic                   q_pop,
  input  logic                   o_full,
  output logic                   o_push,
  output grx_pkg::out_entry_t    o_wdata,
  output grx_pkg::back_status_t  status
);

  logic                        busy_r, busy_nxt;
  logic [grx_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [grx_pkg::PAIRS_W-1:0] npairs_r, npairs_nxt;
  logic [1:0]                  pair_r, pair_nxt;
  logic [1:0]                  sel_r, sel_nxt;
  logic                        issue, last_pair, last_of_row, load;
  logic [1:0]                  code;
  logic [grx_pkg::COLOR_W-1:0] c1, c2;
  logic [grx_pkg::BYTE_W-1:0]  byte_val;

  assign issue       = busy_r && !o_full;
  assign last_pair   = (({1'b0, pair_r} + 3'd1) == npairs_r);
  assign last_of_row = (sel_r == grx_pkg::SEL_GB) && last_pair;
  assign load        = !q_empty && (!busy_r || (issue && last_of_row));
  assign q_pop       = load;

  always_comb begin
    case (pair_r)
      2'd0:    code = row_r[7:6];
      2'd1:    code = row_r[5:4];
      2'd2:    code = row_r[3:2];
      default: code = row_r[1:0];
    endcase
  end

  assign c1 = code[1] ? colors.fg_color : colors.bg_color;
  assign c2 = code[0] ? colors.fg_color : colors.bg_color;

  always_comb begin
    case (sel_r)
      grx_pkg::SEL_RG: byte_val = c1[11:4];
      grx_pkg::SEL_BR: byte_val = {c1[3:0], c2[11:8]};
      default:         byte_val = c2[7:0];
    endcase
  end

  assign o_push             = issue;
  assign o_wdata.pixel_byte = byte_val;
  assign o_wdata.last_byte  = last_of_row;
  assign status.busy        = busy_r;
  assign status.issue       = issue;

  always_comb begin
    busy_nxt   = busy_r;
    row_nxt    = row_r;
    npairs_nxt = npairs_r;
    pair_nxt   = pair_r;
    sel_nxt    = sel_r;
    if (load) begin
      busy_nxt   = 1'b1;
      row_nxt    = q_rdata.row;
      npairs_nxt = q_rdata.pairs;
      pair_nxt   = '0;
      sel_nxt    = grx_pkg::SEL_RG;
    end else if (issue) begin
      if (sel_r == grx_pkg::SEL_GB) begin
        sel_nxt = grx_pkg::SEL_RG;
        if (last_pair) begin
          busy_nxt = 1'b0;
        end else begin
          pair_nxt = pair_r + 1'b1;
        end
      end else begin
        sel_nxt = sel_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pair_r <= '0;
      sel_r  <= grx_pkg::SEL_RG;
    end else begin
      busy_r <= busy_nxt;
      pair_r <= pair_nxt;
      sel_r  <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    npairs_r <= npairs_nxt;
  end

endmodule
